### sv/sha_pkg.sv
// Shared types, codes and constants of the SHA-256 stream hasher.
`default_nettype none

package sha_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned NUM_H   = 8;
  localparam int unsigned BLK_W   = 512;

  // Input operation codes.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Eight chaining words, element 0 is H0.
  typedef logic [NUM_H-1:0][WORD_W-1:0] sha_hash_t;

  localparam sha_hash_t SHA_INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Control from the sequencer to the compression engine.
  typedef struct packed {
    logic start;   // load working vars from the chaining words
    logic reinit;  // return chaining words to the initial value
  } sha_core_ctl_t;

  // Status from the compression engine.
  typedef struct packed {
    logic shift;   // advance the message schedule by one word
    logic done;    // chaining words updated this cycle
  } sha_core_sts_t;

  function automatic logic [31:0] sha_round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### sv/sha_if.sv
// Valid/ready channel interfaces for the hasher input and digest output.
`default_nettype none

interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last,
                  output ready);
endinterface

`default_nettype wire

### sv/sha_core.sv
// SHA-256 compression engine: one round per cycle plus the schedule word.
`default_nettype none

module sha_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sha_pkg::sha_core_ctl_t ctl,
  input  wire logic [31:0]            w0,
  input  wire logic [31:0]            w1,
  input  wire logic [31:0]            w9,
  input  wire logic [31:0]            w14,
  output      logic [31:0]            w_new,
  output      sha_pkg::sha_core_sts_t sts,
  output      sha_pkg::sha_hash_t     hash
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } core_state_t;

  core_state_t        cst_r, cst_nxt;
  sha_pkg::sha_hash_t h_r, h_nxt;
  sha_pkg::sha_hash_t v_r, v_nxt;
  logic [5:0]         rnd_r, rnd_nxt;
  logic [31:0]        t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + sha_pkg::sha_round_k(rnd_r) + w0;
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
          + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;
  end

  always_comb begin
    cst_nxt = cst_r;
    h_nxt   = h_r;
    v_nxt   = v_r;
    rnd_nxt = rnd_r;
    unique case (cst_r)
      C_IDLE: begin
        if (ctl.start) begin
          v_nxt   = h_r;
          rnd_nxt = '0;
          cst_nxt = C_ROUND;
        end
      end
      C_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          cst_nxt = C_ADD;
        end
      end
      C_ADD: begin
        for (int i = 0; i < sha_pkg::NUM_H; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        cst_nxt = C_IDLE;
      end
      default: cst_nxt = C_IDLE;
    endcase
    if (ctl.reinit) begin
      h_nxt = sha_pkg::SHA_INIT_H;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r <= C_IDLE;
      h_r   <= sha_pkg::SHA_INIT_H;
      rnd_r <= '0;
    end else begin
      cst_r <= cst_nxt;
      h_r   <= h_nxt;
      rnd_r <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign sts.shift = (cst_r == C_ROUND);
  assign sts.done  = (cst_r == C_ADD);
  assign hash      = h_r;

endmodule

`default_nettype wire

### sv/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 stream hasher: byte intake, padding and digest output.
//
// Usage: in_if carries one word per message byte (op absorb, data_byte) or a
// finish word (op finish, data_byte ignored). out_if returns the digest as eight
// 32-bit words, word_index 0 to 7, big-endian within each word, last on word 7.
// Timing: an absorb word is taken whenever the block is idle; the word that
// completes a 64-byte block also starts a compression that holds in_if.ready
// low through the 64 rounds on the single round unit and the chaining add (the
// working registers load on the accepting edge). A finish feeds the pad bytes
// one per cycle through the same byte path, runs one or two compressions, then
// presents the digest words one per cycle while out_if.ready is high.
// The shared round unit and the byte-wide block shifter bound the sustained
// rate: no message byte is taken while a compression runs.
// Reset: rst_n is synchronous; it returns the chaining words to the SHA-256
// initial value, clears the byte count and leaves the block ready for a new
// message. After the last digest word the block reinitializes the same way.
// Stalls: while out_if.ready is low the current digest word holds on the port
// and no input word is taken.
`default_nettype none

module sha256_stream_hasher_unit (
  input wire logic clk,
  input wire logic rst_n,
  sha_in_if.sink   in_if,
  sha_out_if.source out_if
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                 st_r, st_nxt;
  logic [sha_pkg::BLK_W-1:0] blk_r, blk_nxt;
  logic [5:0]             pos_r, pos_nxt;
  logic [60:0]            cnt_r, cnt_nxt;
  logic                   pad_r, pad_nxt;
  logic                   mark_r, mark_nxt;
  logic                   len_en_r, len_en_nxt;
  logic                   final_r, final_nxt;
  logic [2:0]             idx_r, idx_nxt;

  logic                   shift_byte;
  logic [7:0]             byte_in;
  logic [7:0]             pad_byte;
  logic [63:0]            bit_len;
  logic                   in_take, out_take;

  sha_pkg::sha_core_ctl_t ctl;
  sha_pkg::sha_core_sts_t sts;
  sha_pkg::sha_hash_t     hash;
  logic [31:0]            w_new;

  sha_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .w0    (blk_r[511:480]),
    .w1    (blk_r[479:448]),
    .w9    (blk_r[223:192]),
    .w14   (blk_r[63:32]),
    .w_new (w_new),
    .sts   (sts),
    .hash  (hash)
  );

  assign in_if.ready = (st_r == S_IDLE);
  assign in_take     = in_if.valid && in_if.ready;
  assign out_take    = out_if.valid && out_if.ready;

  // Message length in bits; pad bytes never bump the count.
  assign bit_len = {cnt_r, 3'b000};

  // Pad byte: the mark first, zeros, then the length from offset 56 on.
  always_comb begin
    if (mark_r) begin
      pad_byte = sha_pkg::PAD_MARK;
    end else if (len_en_r && (pos_r[5:3] == 3'b111)) begin
      pad_byte = bit_len[{~pos_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    pad_nxt    = pad_r;
    mark_nxt   = mark_r;
    len_en_nxt = len_en_r;
    final_nxt  = final_r;
    idx_nxt    = idx_r;
    shift_byte = 1'b0;
    byte_in    = pad_byte;
    ctl        = '0;
    unique case (st_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_if.op == sha_pkg::OP_FINISH) begin
            pad_nxt  = 1'b1;
            mark_nxt = 1'b1;
            st_nxt   = S_PAD;
          end else begin
            shift_byte = 1'b1;
            byte_in    = in_if.data_byte;
            pos_nxt    = pos_r + 6'd1;
            cnt_nxt    = cnt_r + 61'd1;
            if (pos_r == 6'd63) begin
              ctl.start = 1'b1;
              st_nxt    = S_COMP;
            end
          end
        end
      end
      S_PAD: begin
        shift_byte = 1'b1;
        pos_nxt    = pos_r + 6'd1;
        mark_nxt   = 1'b0;
        // Length fits in this block only if the mark lands before offset 56.
        if (mark_r) begin
          len_en_nxt = (pos_r[5:3] != 3'b111);
        end
        if (pos_r == 6'd63) begin
          ctl.start  = 1'b1;
          final_nxt  = len_en_r && !mark_r;
          len_en_nxt = 1'b1;
          st_nxt     = S_COMP;
        end
      end
      S_COMP: begin
        if (sts.done) begin
          if (final_r) begin
            idx_nxt = '0;
            st_nxt  = S_OUT;
          end else if (pad_r) begin
            st_nxt = S_PAD;
          end else begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_take) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            // Drop back to a fresh message.
            ctl.reinit = 1'b1;
            cnt_nxt    = '0;
            pos_nxt    = '0;
            pad_nxt    = 1'b0;
            len_en_nxt = 1'b0;
            final_nxt  = 1'b0;
            st_nxt     = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Block store: bytes shift in at the bottom; during rounds the schedule
  // word shifts in, so the top word is always the current round's word.
  always_comb begin
    if (shift_byte) begin
      blk_nxt = {blk_r[sha_pkg::BLK_W-9:0], byte_in};
    end else if (sts.shift) begin
      blk_nxt = {blk_r[sha_pkg::BLK_W-33:0], w_new};
    end else begin
      blk_nxt = blk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      pos_r    <= '0;
      cnt_r    <= '0;
      pad_r    <= 1'b0;
      mark_r   <= 1'b0;
      len_en_r <= 1'b0;
      final_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      pad_r    <= pad_nxt;
      mark_r   <= mark_nxt;
      len_en_r <= len_en_nxt;
      final_r  <= final_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  // Hold the digest word on the port until taken.
  assign out_if.valid       = (st_r == S_OUT);
  assign out_if.digest_word = hash[idx_r];
  assign out_if.word_index  = idx_r;
  assign out_if.last        = (idx_r == 3'd7);

endmodule

`default_nettype wire
